### rtl/qpno_pkg.sv
// types, widths and field layout for the quic packet number offset parser
package qpno_pkg;

  localparam int OFFSET_W     = 16;
  localparam int CID_W        = 5;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_BITS     = OFFSET_W + 9;
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CID_W-1:0]    SHORT_CID_RESET = CID_W'(8);
  localparam logic [OFFSET_W-1:0] OFFSET_MAX      = {OFFSET_W{1'b1}};

  // result field positions inside out_tdata
  localparam int POS_LEN    = OFFSET_W;
  localparam int POS_LONG   = OFFSET_W + 3;
  localparam int POS_TYPE   = OFFSET_W + 4;
  localparam int POS_NOPN   = OFFSET_W + 6;
  localparam int POS_STATUS = OFFSET_W + 7;

  typedef enum logic [3:0] {
    PH_FIRST   = 4'd0,
    PH_VERSION = 4'd1,
    PH_DCIDLEN = 4'd2,
    PH_DCID    = 4'd3,
    PH_SCIDLEN = 4'd4,
    PH_SCID    = 4'd5,
    PH_TOKLEN  = 4'd6,
    PH_TOKEN   = 4'd7,
    PH_LENVAR  = 4'd8,
    PH_LONGEND = 4'd9,
    PH_RETRY   = 4'd10,
    PH_SHORT   = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SHORT_PKT = 2'd1,
    ST_TRUNC     = 2'd2
  } status_t;

  typedef struct packed {
    status_t             status;
    logic                no_pn;
    logic [1:0]          pkt_type;
    logic                long_hdr;
    logic [2:0]          pn_len;
    logic [OFFSET_W-1:0] offset;
  } result_t;

endpackage

### rtl/quic_packet_number_offset_parser.sv
// quic header walker that reports the packet number offset of each packet
//
//  channel  | signals                                   | role
//  in_      | tvalid tready tdata[7:0] tlast            | packet bytes, tlast on final byte
//  out_     | tvalid tready tdata                       | one result item per packet
//  cfg_     | wr_en wr_data[4:0]                        | short header connection id length
//
// one byte is taken per cycle while in_tready is high;
// the header state and the result are computed in the same cycle and the result
// lands in the output register, in the cycle after the byte that completes it
// in_tready drops only while a result waits and out_tready is low
// rst_n is synchronous, active low; cid length returns to 8
module quic_packet_number_offset_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [qpno_pkg::IN_TDATA_W-1:0]  in_tdata,   // data_byte
  input  logic                             in_tlast,   // last_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pn_offset, pn_length, long_header, packet_type, no_packet_number, status, zero pad
  output logic [qpno_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [qpno_pkg::CID_W-1:0]       cfg_wr_data
);

  localparam int OW = qpno_pkg::OFFSET_W;

  logic [qpno_pkg::CID_W-1:0] short_cid_r;
  qpno_pkg::phase_t           phase_r, phase_nxt;
  logic [OW-1:0]              cnt_r, cnt_nxt;
  logic [OW-1:0]              skip_r, skip_nxt;
  logic [OW-1:0]              vint_r, vint_nxt;
  logic [2:0]                 vleft_r, vleft_nxt;
  logic [7:0]                 hdr_r, hdr_nxt;
  logic                       done_r, done_nxt;
  logic                       out_valid_r;
  qpno_pkg::result_t          res_r, res_nxt;
  logic                       emit;
  logic                       in_fire;

  logic [7:0]    b;
  logic [OW-1:0] vi_val;
  logic [2:0]    vi_left;
  logic          vi_done;
  logic [OW-1:0] skip_dec;

  assign b         = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign skip_dec  = skip_r - OW'(1);

  function automatic qpno_pkg::phase_t after_cids(input logic [7:0] h);
    if (h[7:4] == 4'hf)      return qpno_pkg::PH_RETRY;
    else if (h[7:4] == 4'hc) return qpno_pkg::PH_TOKLEN;
    else                     return qpno_pkg::PH_LENVAR;
  endfunction

  // varint byte step, value saturates at the offset range
  always_comb begin
    if (vleft_r == 3'd0) begin
      vi_val  = OW'(b[5:0]);
      unique case (b[7:6])
        2'd0:    vi_left = 3'd0;
        2'd1:    vi_left = 3'd1;
        2'd2:    vi_left = 3'd3;
        default: vi_left = 3'd7;
      endcase
    end else begin
      vi_left = vleft_r - 3'd1;
      if (vint_r[OW-1:8] != '0) vi_val = qpno_pkg::OFFSET_MAX;
      else                      vi_val = {vint_r[OW-9:0], b};
    end
    vi_done = (vi_left == 3'd0);
  end

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    vint_nxt  = vint_r;
    vleft_nxt = vleft_r;
    hdr_nxt   = hdr_r;
    done_nxt  = done_r;
    cnt_nxt   = cnt_r + OW'(cnt_r != qpno_pkg::OFFSET_MAX);
    emit      = 1'b0;
    res_nxt   = '0;

    if (!done_r) begin
      unique case (phase_r)
        qpno_pkg::PH_FIRST: begin
          hdr_nxt = b;
          if (b[7]) begin
            phase_nxt = qpno_pkg::PH_VERSION;
            skip_nxt  = OW'(4);
          end else begin
            phase_nxt = qpno_pkg::PH_SHORT;
          end
        end
        qpno_pkg::PH_VERSION: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) phase_nxt = qpno_pkg::PH_DCIDLEN;
        end
        qpno_pkg::PH_DCIDLEN: begin
          skip_nxt  = OW'(b);
          phase_nxt = (b != 8'd0) ? qpno_pkg::PH_DCID : qpno_pkg::PH_SCIDLEN;
        end
        qpno_pkg::PH_DCID: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) phase_nxt = qpno_pkg::PH_SCIDLEN;
        end
        qpno_pkg::PH_SCIDLEN: begin
          skip_nxt  = OW'(b);
          phase_nxt = (b != 8'd0) ? qpno_pkg::PH_SCID : after_cids(hdr_r);
        end
        qpno_pkg::PH_SCID: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) phase_nxt = after_cids(hdr_r);
        end
        qpno_pkg::PH_TOKLEN: begin
          vint_nxt  = vi_val;
          vleft_nxt = vi_left;
          if (vi_done) begin
            if (vi_val == '0) begin
              phase_nxt = qpno_pkg::PH_LENVAR;
            end else begin
              skip_nxt  = vi_val;
              phase_nxt = qpno_pkg::PH_TOKEN;
            end
          end
        end
        qpno_pkg::PH_TOKEN: begin
          skip_nxt = skip_dec;
          if (skip_dec == '0) phase_nxt = qpno_pkg::PH_LENVAR;
        end
        qpno_pkg::PH_LENVAR: begin
          vint_nxt  = vi_val;
          vleft_nxt = vi_left;
          if (vi_done) phase_nxt = qpno_pkg::PH_LONGEND;
        end
        default: ;
      endcase

      emit = 1'b1;
      priority if (in_tlast && cnt_nxt < OW'(5)) begin
        res_nxt.status = qpno_pkg::ST_SHORT_PKT;
      end else if (phase_nxt == qpno_pkg::PH_SHORT && cnt_nxt >= OW'(5)) begin
        res_nxt.offset = OW'(short_cid_r) + OW'(1);
      end else if (phase_nxt == qpno_pkg::PH_LONGEND) begin
        res_nxt.offset = cnt_nxt;
      end else if (phase_nxt == qpno_pkg::PH_RETRY && in_tlast) begin
        res_nxt.offset = cnt_nxt;
      end else if (in_tlast) begin
        res_nxt.status = qpno_pkg::ST_TRUNC;
      end else begin
        emit = 1'b0;
      end

      res_nxt.pn_len   = {1'b0, hdr_nxt[1:0]} + 3'd1;
      res_nxt.long_hdr = hdr_nxt[7];
      res_nxt.pkt_type = hdr_nxt[7] ? hdr_nxt[5:4] : 2'd0;
      res_nxt.no_pn    = (hdr_nxt[7:4] == 4'hf);
      if (emit) done_nxt = 1'b1;
    end

    // packet end always returns to the first byte
    if (in_tlast) begin
      phase_nxt = qpno_pkg::PH_FIRST;
      cnt_nxt   = '0;
      skip_nxt  = '0;
      vint_nxt  = '0;
      vleft_nxt = 3'd0;
      hdr_nxt   = 8'd0;
      done_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_cid_r <= qpno_pkg::SHORT_CID_RESET;
      phase_r     <= qpno_pkg::PH_FIRST;
      cnt_r       <= '0;
      skip_r      <= '0;
      vint_r      <= '0;
      vleft_r     <= 3'd0;
      hdr_r       <= 8'd0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) short_cid_r <= cfg_wr_data;
      if (in_fire) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        skip_r  <= skip_nxt;
        vint_r  <= vint_nxt;
        vleft_r <= vleft_nxt;
        hdr_r   <= hdr_nxt;
        done_r  <= done_nxt;
      end
      if (in_fire && emit)  out_valid_r <= 1'b1;
      else if (out_tready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = qpno_pkg::OUT_TDATA_W'(res_r);

endmodule

### rtl/qpno_checker.sv
// port level checks for the quic packet number offset parser, with bind
module qpno_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [qpno_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int OW = qpno_pkg::OFFSET_W;

  logic [OW-1:0] offset;
  logic [2:0]    pn_len;
  logic          long_hdr;
  logic [1:0]    pkt_type;
  logic          no_pn;
  logic [1:0]    status;

  assign offset   = out_tdata[OW-1:0];
  assign pn_len   = out_tdata[qpno_pkg::POS_LEN +: 3];
  assign long_hdr = out_tdata[qpno_pkg::POS_LONG];
  assign pkt_type = out_tdata[qpno_pkg::POS_TYPE +: 2];
  assign no_pn    = out_tdata[qpno_pkg::POS_NOPN];
  assign status   = out_tdata[qpno_pkg::POS_STATUS +: 2];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status != 2'd0 |-> offset == '0)
    else $error("error item with nonzero offset");

  a_pn_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pn_len != 3'd0 && pn_len <= 3'd4 && status != 2'd3)
    else $error("packet number length or status out of range");

  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !long_hdr |-> pkt_type == 2'd0 && !no_pn)
    else $error("short header item with long header fields");

  a_retry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && no_pn |-> long_hdr && pkt_type == 2'd3)
    else $error("no packet number flag on non retry item");

endmodule

bind quic_packet_number_offset_parser qpno_checker u_qpno_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### bench/quic_packet_number_offset_parser_tb.sv
// testbench for the quic packet number offset parser: header walk prediction and result check
module quic_packet_number_offset_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } pkt_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [qpno_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [qpno_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [qpno_pkg::CID_W-1:0] cfg_wr_data = '0;

  always #4 clk = ~clk;

  quic_packet_number_offset_parser uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // header walker state, mirrors the block
  qpno_pkg::phase_t           hdr_phase = qpno_pkg::PH_FIRST;
  int unsigned                byte_cnt = 0;
  int unsigned                skip_left = 0;
  longint unsigned            varint_acc = 0;
  int unsigned                varint_left = 0;
  logic [7:0]                 hdr_byte = '0;
  bit                         reported = 1'b0;
  logic [qpno_pkg::CID_W-1:0] cid_len = qpno_pkg::SHORT_CID_RESET;

  qpno_pkg::result_t due_results[$];
  pkt_byte_t         pending_bytes[$];
  logic [7:0]        pkt_bytes[$];
  pkt_byte_t         cur_byte;

  int errors = 0;
  int packets_sent = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int results_checked = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit in_taken = 1'b0;
  bit calm = 1'b0;

  task automatic flag_mismatch(string what, longint got_v, longint want_v);
    $display("mismatch on %s: got %0d, want %0d", what, got_v, want_v);
    errors++;
  endtask

  function automatic bit is_retry();
    return hdr_byte[7] && hdr_byte[7:4] == 4'hf;
  endfunction

  function automatic qpno_pkg::phase_t after_cids();
    if (is_retry()) return qpno_pkg::PH_RETRY;
    if (hdr_byte[7:4] == 4'hc) return qpno_pkg::PH_TOKLEN;
    return qpno_pkg::PH_LENVAR;
  endfunction

  // one varint byte; true when the varint is complete
  function automatic bit varint_step(logic [7:0] b);
    longint unsigned v;
    if (varint_left == 0) begin
      varint_acc = 64'(b[5:0]);
      varint_left = (1 << b[7:6]) - 1;
    end else begin
      v = varint_acc * 256 + 64'(b);
      varint_acc = (v > qpno_pkg::OFFSET_MAX) ? 64'(qpno_pkg::OFFSET_MAX) : v;
      varint_left--;
    end
    return varint_left == 0;
  endfunction

  task automatic advance_header(logic [7:0] b, logic last);
    bit emit;
    logic [qpno_pkg::OFFSET_W-1:0] off;
    qpno_pkg::status_t st;
    qpno_pkg::result_t r;
    emit = 1'b0;
    off = '0;
    st = qpno_pkg::ST_OK;
    if (byte_cnt < qpno_pkg::OFFSET_MAX) byte_cnt++;
    if (!reported) begin
      case (hdr_phase)
        qpno_pkg::PH_FIRST: begin
          hdr_byte = b;
          if (b[7]) begin
            hdr_phase = qpno_pkg::PH_VERSION;
            skip_left = 4;
          end else begin
            hdr_phase = qpno_pkg::PH_SHORT;
          end
        end
        qpno_pkg::PH_VERSION: begin
          skip_left--;
          if (skip_left == 0) hdr_phase = qpno_pkg::PH_DCIDLEN;
        end
        qpno_pkg::PH_DCIDLEN: begin
          skip_left = 32'(b);
          hdr_phase = (b != 0) ? qpno_pkg::PH_DCID : qpno_pkg::PH_SCIDLEN;
        end
        qpno_pkg::PH_DCID: begin
          skip_left--;
          if (skip_left == 0) hdr_phase = qpno_pkg::PH_SCIDLEN;
        end
        qpno_pkg::PH_SCIDLEN: begin
          skip_left = 32'(b);
          hdr_phase = (b != 0) ? qpno_pkg::PH_SCID : after_cids();
        end
        qpno_pkg::PH_SCID: begin
          skip_left--;
          if (skip_left == 0) hdr_phase = after_cids();
        end
        qpno_pkg::PH_TOKLEN: begin
          if (varint_step(b)) begin
            if (varint_acc == 0) begin
              hdr_phase = qpno_pkg::PH_LENVAR;
            end else begin
              skip_left = 32'(varint_acc);
              hdr_phase = qpno_pkg::PH_TOKEN;
            end
          end
        end
        qpno_pkg::PH_TOKEN: begin
          skip_left--;
          if (skip_left == 0) hdr_phase = qpno_pkg::PH_LENVAR;
        end
        qpno_pkg::PH_LENVAR: begin
          if (varint_step(b)) hdr_phase = qpno_pkg::PH_LONGEND;
        end
        default: ;
      endcase

      if (last && byte_cnt < 5) begin
        emit = 1'b1;
        st = qpno_pkg::ST_SHORT_PKT;
      end else if (hdr_phase == qpno_pkg::PH_SHORT && byte_cnt >= 5) begin
        emit = 1'b1;
        off = qpno_pkg::OFFSET_W'(cid_len) + qpno_pkg::OFFSET_W'(1);
      end else if (hdr_phase == qpno_pkg::PH_LONGEND ||
                   (hdr_phase == qpno_pkg::PH_RETRY && last)) begin
        emit = 1'b1;
        off = qpno_pkg::OFFSET_W'(byte_cnt);
      end else if (last) begin
        emit = 1'b1;
        st = qpno_pkg::ST_TRUNC;
      end
    end

    if (emit) begin
      r.offset = off;
      r.pn_len = 3'(hdr_byte[1:0]) + 3'd1;
      r.long_hdr = hdr_byte[7];
      r.pkt_type = hdr_byte[7] ? hdr_byte[5:4] : 2'd0;
      r.no_pn = is_retry();
      r.status = st;
      due_results.push_back(r);
      reported = 1'b1;
    end

    if (last) begin
      hdr_phase = qpno_pkg::PH_FIRST;
      byte_cnt = 0;
      skip_left = 0;
      varint_acc = 0;
      varint_left = 0;
      hdr_byte = '0;
      reported = 1'b0;
    end
  endtask

  task automatic check_result(qpno_pkg::result_t got);
    qpno_pkg::result_t want;
    if (due_results.size() == 0) begin
      flag_mismatch("result with nothing due, offset", got.offset, 0);
      return;
    end
    want = due_results.pop_front();
    results_checked++;
    if (got.offset !== want.offset) flag_mismatch("pn_offset", got.offset, want.offset);
    if (got.pn_len !== want.pn_len) flag_mismatch("pn_length", got.pn_len, want.pn_len);
    if (got.long_hdr !== want.long_hdr) flag_mismatch("long_header", got.long_hdr, want.long_hdr);
    if (got.pkt_type !== want.pkt_type) flag_mismatch("packet_type", got.pkt_type, want.pkt_type);
    if (got.no_pn !== want.no_pn) flag_mismatch("no_packet_number", got.no_pn, want.no_pn);
    if (got.status !== want.status) flag_mismatch("status code", got.status, want.status);
  endtask

  // prediction and checking on accepted items
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) cid_len = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        advance_header(in_tdata, in_tlast);
        bytes_taken++;
      end
      if (out_tvalid && out_tready)
        check_result(qpno_pkg::result_t'(out_tdata[$bits(qpno_pkg::result_t)-1:0]));
      in_taken <= in_tvalid && in_tready;
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        cur_byte = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= cur_byte.b;
        in_tlast <= cur_byte.last;
        if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with stall bursts
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic put_rand(int n);
    repeat (n) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic put_varint(logic [63:0] v, int n);
    logic [63:0] enc;
    logic [1:0] code;
    code = (n == 1) ? 2'd0 : (n == 2) ? 2'd1 : (n == 4) ? 2'd2 : 2'd3;
    enc = (v & ((64'd1 << (8 * n - 2)) - 64'd1)) | (64'(code) << (8 * n - 2));
    for (int i = n - 1; i >= 0; i--) pkt_bytes.push_back(enc[8 * i +: 8]);
  endtask

  task automatic build_raw(logic [7:0] first, int extra);
    pkt_bytes.push_back(first);
    put_rand(extra);
  endtask

  task automatic build_long(logic [7:0] first, int dcid, int scid, logic [63:0] tok_v,
                            int tok_n, int tok_body, logic [63:0] len_v, int len_n, int tail);
    pkt_bytes.push_back(first);
    put_rand(4);
    pkt_bytes.push_back(8'(dcid));
    put_rand(dcid);
    pkt_bytes.push_back(8'(scid));
    put_rand(scid);
    if (first[7:4] != 4'hf) begin
      if (first[7:4] == 4'hc) begin
        put_varint(tok_v, tok_n);
        put_rand(tok_body);
      end
      put_varint(len_v, len_n);
    end
    put_rand(tail);
  endtask

  task automatic cut_packet(int keep);
    while (pkt_bytes.size() > keep) void'(pkt_bytes.pop_back());
  endtask

  task automatic queue_packet();
    foreach (pkt_bytes[i]) pending_bytes.push_back('{pkt_bytes[i], i == pkt_bytes.size() - 1});
    bytes_queued += pkt_bytes.size();
    packets_sent++;
    pkt_bytes.delete();
  endtask

  function automatic int cid_size();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 49) == 0) return $urandom_range(21, 40);
    return $urandom_range(1, 20);
  endfunction

  function automatic int varint_size();
    return 1 << $urandom_range(0, 3);
  endfunction

  task automatic random_packet();
    int pick;
    int tok;
    logic [7:0] first;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      build_raw({1'b0, 7'($urandom)}, $urandom_range(0, 24));
    end else if (pick < 90) begin
      first = {1'b1, ($urandom_range(0, 7) != 0), 2'($urandom), 4'($urandom)};
      tok = $urandom_range(0, 6);
      build_long(first, cid_size(), cid_size(), tok, varint_size(), tok,
                 {$urandom, $urandom}, varint_size(), $urandom_range(0, 8));
      // broken packets: cut somewhere inside
      if (pick >= 78) cut_packet($urandom_range(1, pkt_bytes.size()));
    end else begin
      build_raw(8'($urandom), $urandom_range(0, 23));
    end
    queue_packet();
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_tvalid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_cid_length(logic [qpno_pkg::CID_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [qpno_pkg::CID_W-1:0] cid_plan[4];
    int target;
    cid_plan[0] = 5'd0;
    cid_plan[1] = 5'd31;
    cid_plan[2] = 5'd20;
    cid_plan[3] = 5'($urandom_range(1, 19));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed packets at the reset cid length
    build_raw(8'h40, 4);  queue_packet();  // short header, cid bytes not all present
    build_raw(8'h7f, 6);  queue_packet();
    build_raw(8'h3e, 3);  queue_packet();  // under five bytes
    build_raw(8'hff, 0);  queue_packet();  // single byte, retry type
    build_raw(8'h80, 3);  queue_packet();
    build_raw(8'hc0, 4);  queue_packet();  // ends with the version
    build_long(8'hc3, 8, 0, 0, 1, 0, 64'h1234, 2, 1); queue_packet();
    build_long(8'hd1, 0, 4, 0, 1, 0, 5, 1, 2); queue_packet();
    build_long(8'he2, 20, 0, 0, 1, 0, 70000, 4, 3); queue_packet();
    build_long(8'hf0, 4, 4, 0, 1, 0, 0, 1, 4); queue_packet();
    build_long(8'hfc, 0, 0, 0, 1, 0, 0, 1, 0); queue_packet();  // retry ends at scid length
    build_long(8'hf5, 9, 0, 0, 1, 0, 0, 1, 0); cut_packet(8); queue_packet();
    build_long(8'h80, 1, 2, 0, 1, 0, 3, 1, 1); queue_packet();
    build_long(8'hb5, 3, 0, 0, 1, 0, 9, 2, 1); queue_packet();  // type bits 3 but no fixed bit
    build_long(8'h95, 0, 6, 0, 1, 0, 1, 1, 0); queue_packet();
    // connection id longer than 20 bytes
    build_long(8'hc1, 24, 0, 5, 2, 5, 64'h55, 1, 2); queue_packet();
    // token length that saturates, packet ends inside the token
    build_long(8'hcf, 3, 3, '1, 8, 0, 0, 1, 0); queue_packet();
    build_long(8'hc2, 2, 2, 0, 1, 0, '1, 8, 1); queue_packet();
    drain();

    foreach (cid_plan[i]) begin
      set_cid_length(cid_plan[i]);
      target = bytes_queued + 20;
      while (bytes_queued < target) random_packet();
      drain();
    end

    // last stretch runs without idling
    calm = 1'b1;
    target = bytes_queued + 20;
    while (bytes_queued < target) random_packet();
    drain();
    repeat (8) @(posedge clk);

    $display("%0d packets, %0d bytes, %0d results checked, %0d mismatches",
             packets_sent, bytes_taken, results_checked, errors);
    $display("short cid lengths 8, 0, 31, 20, %0d; long, retry, truncated, saturated varints",
             cid_plan[3]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
